### rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the preemptive priority scheduler
// Holds the task table entry layout, the operation codes and the time limit.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Operation codes carried on opcode_i
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Field widths fixed by the interface
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One task table entry
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
  } entry_t;

endpackage

### rtl/core/pps_table.sv
// ----------------------------------------------------------------------------
// pps_table: task table storage
// Single write port, single registered read port. A per-entry valid bit,
// cleared by reset, makes an entry never written read back as all zero.
// ----------------------------------------------------------------------------
module pps_table import pps_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i
);

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  entry_t             rd_q;
  logic               rd_ok_q;

  // Write the array and read it back through a register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Track which entries hold data, sample the flag with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Mask entries that were never written
  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: priority scheduler with a task table
// Loads task entries and serves one unit of work per tick to the eligible
// task of highest priority, reporting completion statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode_i and the payload ports and raise start; the transaction is
//   taken at a clock edge where start is high and busy is low. Each
//   transaction yields one result, shown on the result ports for exactly
//   one cycle while done_o is high. The receiver cannot stall; results must
//   be taken in that cycle.
// Sequence:
//   A load reads the old entry from the table, then writes the new entry
//   and gives its result. A tick scans the table one entry per cycle
//   through the single read port, waits out the last read, then updates;
//   when the served task completes, turnaround and waiting are formed in
//   two further steps.
//   busy stays high for the whole operation; done_o may coincide with the
//   acceptance of the next transaction.
// Reset:
//   rst_ni clears the table valid bits, the pending count and the time, so
//   every entry reads as empty right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode_i,
  input  logic [SLOT_W-1:0]    entry_index_i,
  input  logic [PRIO_W-1:0]    priority_req_i,
  input  logic [BURST_W-1:0]   burst_i,
  input  logic [TIME_W-1:0]    arrival_i,
  output logic                 done_o,
  output logic [SLOT_W-1:0]    ran_entry_o,
  output logic                 idle_o,
  output logic                 finished_o,
  output logic [TIME_W-1:0]    finish_time_o,
  output logic [TIME_W-1:0]    turnaround_o,
  output logic [TIME_W-1:0]    waiting_o,
  output logic [TIME_W-1:0]    time_now_o,
  output logic                 all_done_o
);

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LD_WR = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_TAT   = 3'd5;
  localparam logic [2:0] ST_WT    = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       scan_q, scan_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                found_q, found_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  entry_t              best_q, best_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic                done_q, done_d;

  // Latched load request
  logic [AW-1:0]       ld_addr_q;
  logic                ld_ok_q;
  entry_t              ld_ent_q;

  // Result registers
  logic [SLOT_W-1:0]   ran_q, ran_d;
  logic                idle_q, idle_d;
  logic                fin_q, fin_d;
  logic [TIME_W-1:0]   fin_time_q, fin_time_d;
  logic [TIME_W-1:0]   tat_q, tat_d;
  logic [TIME_W-1:0]   wt_q, wt_d;

  // Table port
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  entry_t              cand;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  logic                accept;
  logic [AW+SLOT_W-1:0] slot_wide;
  logic [AW+SLOT_W-1:0] pick_wide;
  logic                slot_in_range;
  logic                take;
  logic [BURST_W-1:0]  rem_after;
  logic [TIME_W:0]     wt_diff;
  logic                old_pend;
  logic                new_pend;

  assign accept        = start && (state_q == ST_IDLE);
  assign slot_wide     = {{AW{1'b0}}, entry_index_i};
  assign pick_wide     = {{SLOT_W{1'b0}}, best_idx_q};
  assign slot_in_range = (32'(entry_index_i) < 32'(MAX_TASKS));

  pps_table #(
    .DEPTH (MAX_TASKS),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (cand),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Compare the entry just read against the best one so far
  assign take = cmp_vld_q && (cand.remaining != '0) && (cand.arrival <= time_q)
                && (!found_q || (cand.prio > best_q.prio));

  assign rem_after = best_q.remaining - BURST_W'(1);
  assign wt_diff   = {1'b0, tat_q} - {{(TIME_W-BURST_W+1){1'b0}}, best_q.burst};
  assign old_pend  = (cand.remaining != '0);
  assign new_pend  = (ld_ent_q.remaining != '0);

  // Sequence loads and ticks
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    cnt_d      = cnt_q;
    time_d     = time_q;
    done_d     = 1'b0;
    ran_d      = ran_q;
    idle_d     = idle_q;
    fin_d      = fin_q;
    fin_time_d = fin_time_q;
    tat_d      = tat_q;
    wt_d       = wt_q;
    rd_en      = 1'b0;
    rd_addr    = scan_q;
    wr_en      = 1'b0;
    wr_addr    = ld_addr_q;
    wr_data    = ld_ent_q;

    // Fold the candidate of the previous read into the best choice
    if (take) begin
      found_d    = 1'b1;
      best_idx_d = cmp_idx_q;
      best_d     = cand;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            // Fetch the old entry to keep the pending count right
            rd_en   = 1'b1;
            rd_addr = slot_wide[AW-1:0];
            state_d = ST_LD_WR;
          end else begin
            scan_d  = '0;
            found_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_LD_WR: begin
        if (ld_ok_q) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(new_pend) - CW'(old_pend);
        end
        ran_d      = '0;
        idle_d     = 1'b1;
        fin_d      = 1'b0;
        fin_time_d = '0;
        tat_d      = '0;
        wt_d       = '0;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SCAN: begin
        // Issue one read a cycle across the table
        rd_en     = 1'b1;
        rd_addr   = scan_q;
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_q;
        if (scan_q == AW'(MAX_TASKS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (time_q != TIME_MAX) begin
          time_d = time_q + TIME_W'(1);
        end
        fin_time_d = '0;
        tat_d      = '0;
        wt_d       = '0;
        fin_d      = 1'b0;
        if (found_q) begin
          wr_en             = 1'b1;
          wr_addr           = best_idx_q;
          wr_data           = best_q;
          wr_data.remaining = rem_after;
          ran_d             = pick_wide[SLOT_W-1:0];
          idle_d            = 1'b0;
          if (rem_after == '0) begin
            fin_d   = 1'b1;
            cnt_d   = cnt_q - CW'(1);
            state_d = ST_TAT;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          ran_d   = '0;
          idle_d  = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_TAT: begin
        fin_time_d = time_q;
        tat_d      = time_q - best_q.arrival;
        state_d    = ST_WT;
      end
      ST_WT: begin
        // Clamp waiting at zero once time has saturated
        wt_d    = wt_diff[TIME_W] ? '0 : wt_diff[TIME_W-1:0];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      cnt_q     <= '0;
      time_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      cnt_q     <= cnt_d;
      time_q    <= time_d;
      done_q    <= done_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    ran_q      <= ran_d;
    idle_q     <= idle_d;
    fin_q      <= fin_d;
    fin_time_q <= fin_time_d;
    tat_q      <= tat_d;
    wt_q       <= wt_d;
    if (accept) begin
      ld_addr_q          <= slot_wide[AW-1:0];
      ld_ok_q            <= slot_in_range;
      ld_ent_q.prio      <= priority_req_i;
      ld_ent_q.arrival   <= arrival_i;
      ld_ent_q.burst     <= burst_i;
      ld_ent_q.remaining <= burst_i;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign ran_entry_o   = ran_q;
  assign idle_o        = idle_q;
  assign finished_o    = fin_q;
  assign finish_time_o = fin_time_q;
  assign turnaround_o  = tat_q;
  assign waiting_o     = wt_q;
  assign time_now_o    = time_q;
  assign all_done_o    = (cnt_q == '0);

  // Results appear only once the sequencer is back at rest
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // An accepted transaction always occupies the block
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction left block idle");

  // An idle result never reports a completion
  a_idle_nofin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && idle_o) |-> !finished_o) else $error("idle result marked finished");

  // Waiting never exceeds turnaround
  a_wait_le_tat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && finished_o) |-> (waiting_o <= turnaround_o))
    else $error("waiting above turnaround");

  // Time never runs backward
  a_time_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(time_now_o) <= time_now_o) else $error("time decreased");

endmodule
